### src/lil_pkg.sv
// Shared types and constants for the learned index lookup block.
package lil_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int MODEL_DEPTH_DEF = 256;

    localparam int KEY_BITS      = 32;
    localparam int VALUE_BITS    = 32;
    localparam int FRAC_BITS     = 32;
    localparam int COEF_BITS     = 64;
    localparam int HALF_BITS     = COEF_BITS / 2;
    localparam int SLOT_BITS     = 12;
    localparam int POS_BITS      = 12;
    localparam int PROBE_BITS    = 13;
    localparam int CMD_BITS      = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;
    localparam int TCOUNT_BITS   = 13;
    localparam int MCOUNT_BITS   = 9;
    localparam int STEP_BITS     = 13;

    localparam logic [CMD_BITS-1:0] CMD_WRITE_ENTRY = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_WRITE_MODEL = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_LOOKUP      = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TABLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODEL_COUNT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SEARCH_STEP = 2'd2;

    localparam logic [TCOUNT_BITS-1:0] TCOUNT_RESET = 13'd0;
    localparam logic [MCOUNT_BITS-1:0] MCOUNT_RESET = 9'd1;
    localparam logic [STEP_BITS-1:0]   STEP_RESET   = 13'd14;

    typedef struct packed {
        logic [CMD_BITS-1:0]          cmd;
        logic [SLOT_BITS-1:0]         slot;
        logic [KEY_BITS-1:0]          key;
        logic [VALUE_BITS-1:0]        entry_value;
        logic signed [COEF_BITS-1:0]  slope;
        logic signed [COEF_BITS-1:0]  intercept;
    } in_item_t;

    typedef struct packed {
        logic                   found;
        logic [POS_BITS-1:0]    position;
        logic [VALUE_BITS-1:0]  result_value;
        logic [PROBE_BITS-1:0]  probes;
    } out_item_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] slope;
        logic signed [COEF_BITS-1:0] intercept;
        logic [KEY_BITS-1:0]         key;
    } eval_req_t;

endpackage

### src/lil_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/lil_model_eval.sv
// Linear model evaluation: slope*key + intercept, floor to integer, clamp to [0, limit].
module lil_model_eval #(
    parameter int LIM_W = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  lil_pkg::eval_req_t req,
    input  logic [LIM_W-1:0]   limit,
    output logic               done,
    output logic [LIM_W-1:0]   result
);

    import lil_pkg::*;

    localparam int PW    = HALF_BITS + KEY_BITS + 2;
    localparam int ACC_W = COEF_BITS + KEY_BITS + 1;
    localparam int IPW   = ACC_W - FRAC_BITS;

    typedef enum logic [2:0] {
        EV_IDLE,
        EV_MUL_LO,
        EV_MUL_HI,
        EV_SUM,
        EV_CLAMP
    } ev_state_t;

    ev_state_t          state_reg;
    eval_req_t          req_reg;
    logic [LIM_W-1:0]   limit_reg;
    logic signed [PW-1:0] prod_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic               done_reg;
    logic [LIM_W-1:0]   result_reg;

    logic signed [HALF_BITS:0] mul_a;
    logic signed [KEY_BITS:0]  mul_b;
    logic signed [PW-1:0]      mul_p;
    logic [ACC_W-1:0]          icpt_ext;
    logic [ACC_W-1:0]          prod_ext;
    logic [ACC_W-1:0]          prod_shl;
    logic [IPW-1:0]            int_part;
    logic [LIM_W-1:0]          clamped;

    // one shared multiplier: low slope half first, then signed high half
    assign mul_a = (state_reg == EV_MUL_LO)
                 ? $signed({1'b0, req_reg.slope[HALF_BITS-1:0]})
                 : $signed({req_reg.slope[COEF_BITS-1], req_reg.slope[COEF_BITS-1:HALF_BITS]});
    assign mul_b = $signed({1'b0, req_reg.key});
    assign mul_p = mul_a * mul_b;

    assign icpt_ext = {{(ACC_W-COEF_BITS){req_reg.intercept[COEF_BITS-1]}}, req_reg.intercept};
    assign prod_ext = {{(ACC_W-PW){prod_reg[PW-1]}}, prod_reg};
    assign prod_shl = {prod_reg[ACC_W-HALF_BITS-1:0], {HALF_BITS{1'b0}}};
    assign int_part = acc_reg[ACC_W-1:FRAC_BITS];

    always_comb begin
        if (acc_reg[ACC_W-1]) begin
            clamped = '0;
        end else if (int_part > IPW'(limit_reg)) begin
            clamped = limit_reg;
        end else begin
            clamped = LIM_W'(int_part);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                EV_IDLE: begin
                    if (start) begin
                        req_reg   <= req;
                        limit_reg <= limit;
                        state_reg <= EV_MUL_LO;
                    end
                end
                EV_MUL_LO: begin
                    prod_reg  <= mul_p;
                    state_reg <= EV_MUL_HI;
                end
                EV_MUL_HI: begin
                    acc_reg   <= icpt_ext + prod_ext;
                    prod_reg  <= mul_p;
                    state_reg <= EV_SUM;
                end
                EV_SUM: begin
                    acc_reg   <= acc_reg + prod_shl;
                    state_reg <= EV_CLAMP;
                end
                EV_CLAMP: begin
                    result_reg <= clamped;
                    done_reg   <= 1'b1;
                    state_reg  <= EV_IDLE;
                end
                default: state_reg <= EV_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### src/lil_ctrl.sv
// Command decode, configuration registers, lookup sequencer and result register.
module lil_ctrl #(
    parameter int TABLE_DEPTH = lil_pkg::TABLE_DEPTH_DEF,
    parameter int MODEL_DEPTH = lil_pkg::MODEL_DEPTH_DEF,
    localparam int TW    = $clog2(TABLE_DEPTH),
    localparam int MW    = (MODEL_DEPTH > 1) ? $clog2(MODEL_DEPTH) : 1,
    localparam int LW    = (TW > MW) ? TW : MW,
    localparam int TBL_W = lil_pkg::KEY_BITS + lil_pkg::VALUE_BITS,
    localparam int MDL_W = 2 * lil_pkg::COEF_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  lil_pkg::in_item_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output lil_pkg::out_item_t                 m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lil_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [lil_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output logic                               tbl_we,
    output logic [TW-1:0]                      tbl_waddr,
    output logic [TBL_W-1:0]                   tbl_wdata,
    output logic [TW-1:0]                      tbl_raddr,
    input  logic [TBL_W-1:0]                   tbl_rdata,
    output logic                               mdl_we,
    output logic [MW-1:0]                      mdl_waddr,
    output logic [MDL_W-1:0]                   mdl_wdata,
    output logic [MW-1:0]                      mdl_raddr,
    input  logic [MDL_W-1:0]                   mdl_rdata,
    output logic                               ev_start,
    output lil_pkg::eval_req_t                 ev_req,
    output logic [LW-1:0]                      ev_limit,
    input  logic                               ev_done,
    input  logic [LW-1:0]                      ev_result
);

    import lil_pkg::*;

    localparam int NW = (TW + 1 > TCOUNT_BITS) ? TW + 1 : TCOUNT_BITS;
    localparam int FW = (MW + 1 > MCOUNT_BITS) ? MW + 1 : MCOUNT_BITS;
    localparam int CW = ((TW > STEP_BITS) ? TW : STEP_BITS) + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MODEL_RD,
        ST_MODEL_GO,
        ST_MODEL_WAIT,
        ST_GL_RD,
        ST_GL_CMP,
        ST_GR_RD,
        ST_GR_CMP,
        ST_BS_RD,
        ST_BS_CMP,
        ST_FIN,
        ST_EMPTY
    } state_t;

    state_t                  state_reg;
    logic [TCOUNT_BITS-1:0]  table_count_reg;
    logic [MCOUNT_BITS-1:0]  model_count_reg;
    logic [STEP_BITS-1:0]    search_step_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [TW-1:0]           nm1_reg;
    logic [MW-1:0]           fanm1_reg;
    logic [STEP_BITS-1:0]    step_reg;
    logic                    stage_reg;
    logic [MW-1:0]           maddr_reg;
    logic [TW-1:0]           left_reg;
    logic [TW-1:0]           right_reg;
    logic [TW-1:0]           mid_reg;
    logic [PROBE_BITS-1:0]   probes_reg;
    logic                    m_valid_reg;
    out_item_t               out_reg;

    logic                    accept;
    logic [NW-1:0]           n_ext;
    logic [NW-1:0]           n_sat;
    logic [FW-1:0]           f_ext;
    logic [FW-1:0]           f_sat;
    logic [TW-1:0]           nm1;
    logic [MW-1:0]           fanm1;
    logic [STEP_BITS-1:0]    step_eff;
    logic [CW-1:0]           step_ext;
    logic [CW-1:0]           left_ext;
    logic [TW-1:0]           left_dec;
    logic [TW-1:0]           gap;
    logic [TW-1:0]           right_inc;
    logic [TW-1:0]           mid;
    logic [PROBE_BITS-1:0]   probes_inc;
    logic [KEY_BITS-1:0]     kd;
    logic [VALUE_BITS-1:0]   vd;
    logic                    out_free;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // saturated counts, captured when a lookup is taken
    assign n_ext = NW'(table_count_reg);
    assign n_sat = (n_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : n_ext;
    assign nm1   = TW'(n_sat - NW'(1));
    assign f_ext = (model_count_reg == '0) ? FW'(1) : FW'(model_count_reg);
    assign f_sat = (f_ext > FW'(MODEL_DEPTH)) ? FW'(MODEL_DEPTH) : f_ext;
    assign fanm1 = MW'(f_sat - FW'(1));
    assign step_eff = (search_step_reg == '0) ? STEP_BITS'(1) : search_step_reg;

    assign step_ext   = CW'(step_reg);
    assign left_ext   = CW'(left_reg);
    assign left_dec   = (left_ext > step_ext) ? TW'(left_ext - step_ext) : '0;
    assign gap        = nm1_reg - right_reg;
    assign right_inc  = (CW'(gap) > step_ext) ? right_reg + TW'(step_reg) : nm1_reg;
    assign mid        = left_reg + ((right_reg - left_reg) >> 1);
    assign probes_inc = (probes_reg == '1) ? probes_reg : probes_reg + PROBE_BITS'(1);

    assign kd       = tbl_rdata[KEY_BITS-1:0];
    assign vd       = tbl_rdata[TBL_W-1:KEY_BITS];
    assign out_free = !m_valid_reg || m_ready;

    // writes land in the cycle of the transaction
    assign tbl_we    = accept && (s_data.cmd == CMD_WRITE_ENTRY)
                     && (int'(s_data.slot) < TABLE_DEPTH);
    assign tbl_waddr = TW'(s_data.slot);
    assign tbl_wdata = {s_data.entry_value, s_data.key};
    assign mdl_we    = accept && (s_data.cmd == CMD_WRITE_MODEL)
                     && (int'(s_data.slot) < MODEL_DEPTH);
    assign mdl_waddr = MW'(s_data.slot);
    assign mdl_wdata = {s_data.slope, s_data.intercept};
    assign mdl_raddr = maddr_reg;

    always_comb begin
        case (state_reg)
            ST_GR_RD: tbl_raddr = right_reg;
            ST_BS_RD: tbl_raddr = (left_reg < right_reg) ? mid : left_reg;
            default:  tbl_raddr = left_reg;
        endcase
    end

    assign ev_start         = (state_reg == ST_MODEL_GO);
    assign ev_req.slope     = mdl_rdata[MDL_W-1:COEF_BITS];
    assign ev_req.intercept = mdl_rdata[COEF_BITS-1:0];
    assign ev_req.key       = key_reg;
    assign ev_limit         = stage_reg ? LW'(nm1_reg) : LW'(fanm1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            table_count_reg <= TCOUNT_RESET;
            model_count_reg <= MCOUNT_RESET;
            search_step_reg <= STEP_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_TABLE_COUNT: table_count_reg <= cfg_data[TCOUNT_BITS-1:0];
                    CFG_MODEL_COUNT: model_count_reg <= cfg_data[MCOUNT_BITS-1:0];
                    CFG_SEARCH_STEP: search_step_reg <= cfg_data[STEP_BITS-1:0];
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_data.cmd == CMD_LOOKUP)) begin
                        key_reg    <= s_data.key;
                        nm1_reg    <= nm1;
                        fanm1_reg  <= fanm1;
                        step_reg   <= step_eff;
                        probes_reg <= '0;
                        stage_reg  <= 1'b0;
                        maddr_reg  <= '0;
                        state_reg  <= (table_count_reg == '0) ? ST_EMPTY : ST_MODEL_RD;
                    end
                end
                ST_MODEL_RD: state_reg <= ST_MODEL_GO;
                ST_MODEL_GO: state_reg <= ST_MODEL_WAIT;
                ST_MODEL_WAIT: begin
                    if (ev_done) begin
                        if (!stage_reg) begin
                            maddr_reg <= MW'(ev_result);
                            stage_reg <= 1'b1;
                            state_reg <= ST_MODEL_RD;
                        end else begin
                            left_reg  <= TW'(ev_result);
                            right_reg <= TW'(ev_result);
                            state_reg <= ST_GL_RD;
                        end
                    end
                end
                ST_GL_RD: state_reg <= (left_reg == '0) ? ST_GR_RD : ST_GL_CMP;
                ST_GL_CMP: begin
                    if (kd > key_reg) begin
                        left_reg   <= left_dec;
                        probes_reg <= probes_inc;
                        state_reg  <= ST_GL_RD;
                    end else begin
                        state_reg <= ST_GR_RD;
                    end
                end
                ST_GR_RD: state_reg <= (right_reg < nm1_reg) ? ST_GR_CMP : ST_BS_RD;
                ST_GR_CMP: begin
                    if (kd < key_reg) begin
                        right_reg  <= right_inc;
                        probes_reg <= probes_inc;
                        state_reg  <= ST_GR_RD;
                    end else begin
                        state_reg <= ST_BS_RD;
                    end
                end
                ST_BS_RD: begin
                    if (left_reg < right_reg) begin
                        mid_reg    <= mid;
                        probes_reg <= probes_inc;
                        state_reg  <= ST_BS_CMP;
                    end else begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_BS_CMP: begin
                    if (kd < key_reg) begin
                        left_reg <= mid_reg + TW'(1);
                    end else begin
                        right_reg <= mid_reg;
                    end
                    state_reg <= ST_BS_RD;
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_valid_reg          <= 1'b1;
                        out_reg.found        <= (kd == key_reg);
                        out_reg.position     <= POS_BITS'(left_reg);
                        out_reg.result_value <= (kd == key_reg) ? vd : '0;
                        out_reg.probes       <= probes_reg;
                        state_reg            <= ST_IDLE;
                    end
                end
                ST_EMPTY: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        out_reg     <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

### src/learned_index_lookup.sv
// Learned index lookup: sorted key/value table searched from a two-level linear model guess.
//
// Usage:
//   s_ channel takes commands: write table entry, write model, or lookup.
//   Writes land when taken and produce no m_ transaction; command code three
//   is dropped. A lookup produces exactly one m_ transaction.
//   cfg_ channel writes table_count, model_count and search_step; always ready.
//   Write it only while no lookup is in flight; the block does not enforce this.
// Sequencing:
//   One lookup at a time. Each model evaluation (router, then leaf) is a
//   model RAM read followed by four evaluator steps (low product, high
//   product plus intercept, shifted sum, clamp) on one shared 33x33
//   multiplier. Each gallop or bisection probe is a key RAM read, then a
//   compare; a final read gives the result. An empty table skips model
//   evaluation and search.
// Reset:
//   aresetn (synchronous, active low) restores the register defaults and
//   clears the sequencer; table and model contents are kept, unknown until
//   written.
// Stall:
//   The result sits in an output register; writes are still taken while
//   it waits, and a finished lookup holds until the register is free.
module learned_index_lookup #(
    parameter int TABLE_DEPTH = lil_pkg::TABLE_DEPTH_DEF,
    parameter int MODEL_DEPTH = lil_pkg::MODEL_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  lil_pkg::in_item_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output lil_pkg::out_item_t                 m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lil_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [lil_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    import lil_pkg::*;

    localparam int TW    = $clog2(TABLE_DEPTH);
    localparam int MW    = (MODEL_DEPTH > 1) ? $clog2(MODEL_DEPTH) : 1;
    localparam int LW    = (TW > MW) ? TW : MW;
    localparam int TBL_W = KEY_BITS + VALUE_BITS;
    localparam int MDL_W = 2 * COEF_BITS;

    logic              tbl_we;
    logic [TW-1:0]     tbl_waddr;
    logic [TBL_W-1:0]  tbl_wdata;
    logic [TW-1:0]     tbl_raddr;
    logic [TBL_W-1:0]  tbl_rdata;
    logic              mdl_we;
    logic [MW-1:0]     mdl_waddr;
    logic [MDL_W-1:0]  mdl_wdata;
    logic [MW-1:0]     mdl_raddr;
    logic [MDL_W-1:0]  mdl_rdata;
    logic              ev_start;
    eval_req_t         ev_req;
    logic [LW-1:0]     ev_limit;
    logic              ev_done;
    logic [LW-1:0]     ev_result;

    lil_ram #(
        .WIDTH (TBL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    lil_ram #(
        .WIDTH (MDL_W),
        .DEPTH (MODEL_DEPTH)
    ) u_model_ram (
        .aclk  (aclk),
        .we    (mdl_we),
        .waddr (mdl_waddr),
        .wdata (mdl_wdata),
        .raddr (mdl_raddr),
        .rdata (mdl_rdata)
    );

    lil_model_eval #(
        .LIM_W (LW)
    ) u_model_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ev_start),
        .req     (ev_req),
        .limit   (ev_limit),
        .done    (ev_done),
        .result  (ev_result)
    );

    lil_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MODEL_DEPTH (MODEL_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tbl_we    (tbl_we),
        .tbl_waddr (tbl_waddr),
        .tbl_wdata (tbl_wdata),
        .tbl_raddr (tbl_raddr),
        .tbl_rdata (tbl_rdata),
        .mdl_we    (mdl_we),
        .mdl_waddr (mdl_waddr),
        .mdl_wdata (mdl_wdata),
        .mdl_raddr (mdl_raddr),
        .mdl_rdata (mdl_rdata),
        .ev_start  (ev_start),
        .ev_req    (ev_req),
        .ev_limit  (ev_limit),
        .ev_done   (ev_done),
        .ev_result (ev_result)
    );

endmodule

### bench/lookup_checker.sv
`timescale 1ns / 1ps
// Checker for learned_index_lookup: mirrors table, models and registers, predicts and compares lookups.
module lookup_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  lil_pkg::in_item_t                  s_data,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  lil_pkg::out_item_t                 m_data,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [lil_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [lil_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                 mismatches,
    output int                                 pending,
    output int                                 hits
);
    import lil_pkg::*;

    logic [KEY_BITS-1:0]         key_mem   [TABLE_DEPTH_DEF];
    logic [VALUE_BITS-1:0]       value_mem [TABLE_DEPTH_DEF];
    logic signed [COEF_BITS-1:0] slope_mem [MODEL_DEPTH_DEF];
    logic signed [COEF_BITS-1:0] icept_mem [MODEL_DEPTH_DEF];
    logic [TCOUNT_BITS-1:0]      table_count;
    logic [MCOUNT_BITS-1:0]      model_count;
    logic [STEP_BITS-1:0]        search_step;
    out_item_t                   answers_due [$];

    initial begin
        mismatches = 0;
        pending = 0;
        hits = 0;
    end

    // floor((slope * key + intercept) / 2^FRAC_BITS), clamped to [0, limit]
    function automatic int unsigned fit_position(int unsigned idx, logic [KEY_BITS-1:0] k,
                                                 int unsigned limit);
        logic signed [127:0] acc;
        acc = slope_mem[idx] * $signed({96'd0, k}) + icept_mem[idx];
        if (acc < 0) return 0;
        acc = acc >>> FRAC_BITS;
        if (acc > limit) return limit;
        return acc[31:0];
    endfunction

    function automatic out_item_t rmi_search(logic [KEY_BITS-1:0] k);
        int unsigned n, fan, stride, leaf, lo, hi, mid, cnt;
        out_item_t r;
        r = '0;
        n = (table_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : table_count;
        if (n == 0) return r;
        fan = (model_count == 0) ? 1 : model_count;
        if (fan > MODEL_DEPTH_DEF) fan = MODEL_DEPTH_DEF;
        stride = (search_step == 0) ? 1 : search_step;
        leaf = fit_position(0, k, fan - 1);
        lo = fit_position(leaf, k, n - 1);
        hi = lo;
        cnt = 0;
        while (lo > 0 && key_mem[lo] > k) begin
            lo = (lo > stride) ? lo - stride : 0;
            cnt++;
        end
        while (hi < n - 1 && key_mem[hi] < k) begin
            hi = (n - 1 - hi > stride) ? hi + stride : n - 1;
            cnt++;
        end
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            cnt++;
            if (key_mem[mid] < k) lo = mid + 1;
            else hi = mid;
        end
        if (lo < n && key_mem[lo] == k) begin
            r.found = 1'b1;
            r.result_value = value_mem[lo];
        end
        r.position = lo[POS_BITS-1:0];
        r.probes = (cnt > 8191) ? 13'd8191 : cnt[PROBE_BITS-1:0];
        return r;
    endfunction

    task automatic check_field(string what, logic [63:0] want_v, logic [63:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        out_item_t want;
        if (!aresetn) begin
            table_count = TCOUNT_RESET;
            model_count = MCOUNT_RESET;
            search_step = STEP_RESET;
            answers_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: result with no lookup outstanding, expected none, got %p",
                             $time, m_data);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    if (want.found) hits++;
                    check_field("found", want.found, m_data.found);
                    check_field("position", want.position, m_data.position);
                    check_field("result_value", want.result_value, m_data.result_value);
                    check_field("probes", want.probes, m_data.probes);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TABLE_COUNT: table_count = cfg_data[TCOUNT_BITS-1:0];
                    CFG_MODEL_COUNT: model_count = cfg_data[MCOUNT_BITS-1:0];
                    CFG_SEARCH_STEP: search_step = cfg_data[STEP_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_data.cmd)
                    CMD_WRITE_ENTRY: begin
                        key_mem[s_data.slot] = s_data.key;
                        value_mem[s_data.slot] = s_data.entry_value;
                    end
                    CMD_WRITE_MODEL: begin
                        if (s_data.slot < MODEL_DEPTH_DEF) begin
                            slope_mem[s_data.slot] = s_data.slope;
                            icept_mem[s_data.slot] = s_data.intercept;
                        end
                    end
                    CMD_LOOKUP: answers_due.push_back(rmi_search(s_data.key));
                    default: ;
                endcase
            end
        end
        pending = answers_due.size();
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Testbench top for learned_index_lookup: clock, reset, stimulus, flow control and verdict.
module tb;
    import lil_pkg::*;

    localparam int LIMIT        = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1350;
    localparam logic [CFG_IDX_BITS-1:0]     CFG_UNUSED   = 2'd3;
    localparam logic [CMD_BITS-1:0]         CMD_RESERVED = 2'd3;
    localparam logic signed [COEF_BITS-1:0] COEF_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [COEF_BITS-1:0] COEF_MIN     = 64'sh8000_0000_0000_0000;
    localparam logic signed [COEF_BITS-1:0] ONE_FX       = 64'sh0000_0001_0000_0000;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    in_item_t                  s_data;
    logic                      m_valid;
    logic                      m_ready;
    out_item_t                 m_data;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int mismatches;
    int pending;
    int hits;
    int cycles = 0;
    int stall_ticket = 0;
    int stall_served = 0;
    bit calm = 1'b0;
    int n_lookups = 0;
    int n_writes = 0;
    int n_settings = 0;

    logic [KEY_BITS-1:0] shadow_key [TABLE_DEPTH_DEF];
    longint key_base = 0;
    longint key_gap = 1;

    learned_index_lookup uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lookup_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .hits       (hits)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_ticket != stall_served) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                stall_served = stall_served + 1;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 34);
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic signed [63:0] sat64(logic signed [127:0] v);
        if (v > COEF_MAX) return COEF_MAX;
        if (v < COEF_MIN) return COEF_MIN;
        return v[63:0];
    endfunction

    function automatic in_item_t scramble(logic [CMD_BITS-1:0] c);
        in_item_t it;
        it.cmd = c;
        it.slot = $urandom_range(0, 4095);
        it.key = $urandom;
        it.entry_value = $urandom;
        it.slope = rand64();
        it.intercept = rand64();
        return it;
    endfunction

    // called at a falling edge; leaves valid high after the transaction
    task automatic push_cmd(in_item_t it);
        while (!calm && $urandom_range(0, 99) < 34) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic put_entry(logic [SLOT_BITS-1:0] slot, logic [KEY_BITS-1:0] k,
                             logic [VALUE_BITS-1:0] v);
        in_item_t it;
        it = scramble(CMD_WRITE_ENTRY);
        it.slot = slot;
        it.key = k;
        it.entry_value = v;
        push_cmd(it);
        shadow_key[slot] = k;
        n_writes++;
    endtask

    task automatic put_model(logic [SLOT_BITS-1:0] slot, logic signed [COEF_BITS-1:0] sl,
                             logic signed [COEF_BITS-1:0] ic);
        in_item_t it;
        it = scramble(CMD_WRITE_MODEL);
        it.slot = slot;
        it.slope = sl;
        it.intercept = ic;
        push_cmd(it);
        n_writes++;
    endtask

    task automatic lookup(logic [KEY_BITS-1:0] k);
        in_item_t it;
        it = scramble(CMD_LOOKUP);
        it.key = k;
        push_cmd(it);
        n_lookups++;
    endtask

    task automatic reg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_regs(int unsigned tc, int unsigned mc, int unsigned st);
        reg_write(CFG_TABLE_COUNT, tc[12:0]);
        reg_write(CFG_MODEL_COUNT, {4'($urandom), mc[8:0]});
        reg_write(CFG_SEARCH_STEP, st[12:0]);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // wait until every lookup has answered and trailing writes are done
    task automatic settle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // nondecreasing keys with occasional duplicates
    task automatic load_sorted(int unsigned n);
        longint k;
        int i;
        key_gap = $urandom_range(1, 1 << $urandom_range(0, 18));
        key_base = $urandom_range(0, 32'hFFFF_FFFF - 32'(n * key_gap));
        for (i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 7) == 0) k = shadow_key[i - 1];
            else k = key_base + i * key_gap + $urandom_range(0, key_gap - 1);
            put_entry(i, k[31:0], $urandom);
        end
    endtask

    // router in model 0, leaves with the ideal fit plus a random position error
    task automatic load_models(int unsigned fan, int unsigned n, int spread);
        longint rs, ls;
        logic signed [127:0] wide;
        int j, off;
        rs = (longint'(fan) << 32) / (longint'(n) * key_gap);
        ls = (longint'(1) << 32) / key_gap;
        wide = -(rs * $signed({64'd0, key_base}));
        put_model(0, rs, sat64(wide));
        for (j = 1; j < fan; j++) begin
            off = int'($urandom_range(0, 2 * spread)) - spread;
            wide = -(ls * $signed({64'd0, key_base})) + off * ONE_FX;
            put_model(j, ls, sat64(wide));
        end
    endtask

    initial begin : stimulus
        int unsigned n, n_reg, fan, fan_reg, stride, pick, looks, phase, mark;
        int spread, j;
        logic [KEY_BITS-1:0] k;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty table straight out of reset, dropped command, out-of-range model slots
        lookup('0);
        lookup('1);
        push_cmd(scramble(CMD_RESERVED));
        put_model(12'd300, rand64(), rand64());
        put_model(12'hFFF, COEF_MAX, COEF_MIN);

        for (j = 0; j < MODEL_DEPTH_DEF; j++) put_model(j, rand64(), rand64());
        load_sorted(TABLE_DEPTH_DEF);

        settle();
        reg_write(CFG_UNUSED, 13'h1FFF);
        set_regs(TABLE_DEPTH_DEF, 1, 14);
        put_model(0, COEF_MAX, COEF_MIN);
        lookup('0);
        lookup('1);
        lookup(shadow_key[2048]);
        put_model(0, COEF_MIN, COEF_MAX);
        lookup(shadow_key[0]);
        lookup('1);
        put_model(0, '0, '0);
        lookup(shadow_key[4095]);
        lookup(shadow_key[0]);

        // table count above depth, zero fanout, zero step
        settle();
        set_regs(8191, 0, 0);
        lookup(shadow_key[4095]);
        lookup('1);

        // fanout above depth routes to the last leaf, step wider than the table
        settle();
        set_regs(TABLE_DEPTH_DEF, 511, 8191);
        put_model(0, COEF_MAX, '0);
        put_model(255, '0, 64'sh0000_07D0_0000_0000);
        lookup(shadow_key[0]);
        lookup(shadow_key[4095]);
        lookup(shadow_key[2000]);

        mark = n_writes + n_lookups;
        phase = 0;
        while (n_writes + n_lookups - mark < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) n = $urandom_range(1, 64);
            else if (pick < 90) n = $urandom_range(65, 256);
            else n = 0;
            if (n == 0) begin
                n_reg = $urandom_range(257, 8191);
                n = (n_reg > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : n_reg;
            end else begin
                n_reg = n;
            end

            pick = $urandom_range(0, 99);
            if (pick < 55) fan_reg = $urandom_range(1, 8);
            else if (pick < 80) fan_reg = $urandom_range(9, 32);
            else if (pick < 90) fan_reg = MODEL_DEPTH_DEF;
            else fan_reg = $urandom_range(0, 1) ? 0 : $urandom_range(257, 511);
            fan = (fan_reg == 0) ? 1 : ((fan_reg > MODEL_DEPTH_DEF) ? MODEL_DEPTH_DEF : fan_reg);

            pick = $urandom_range(0, 99);
            if (n_reg > 256) stride = $urandom_range(16, 8191);
            else if (pick < 50) stride = $urandom_range(1, 16);
            else if (pick < 80) stride = 14;
            else stride = $urandom_range(0, 8191);

            calm = (phase >= 5 && phase <= 7);
            settle();
            set_regs(n_reg, fan_reg, stride);
            if (n_reg <= 256) load_sorted(n);
            spread = $urandom_range(0, n / 2);
            load_models(fan, n, spread);
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 4)) put_model($urandom_range(0, fan - 1), rand64(), rand64());

            if (phase == 2) stall_ticket = stall_ticket + 1;

            looks = $urandom_range(8, 40);
            repeat (looks) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    push_cmd(scramble(CMD_RESERVED));
                end else if (pick < 8) begin
                    put_entry($urandom_range(0, 4095), $urandom, $urandom);
                end else if (pick < 10) begin
                    put_model($urandom_range(0, 4095), rand64(), rand64());
                end else begin
                    k = shadow_key[$urandom_range(0, n - 1)];
                    if (pick < 60) ;
                    else if (pick < 75) k = $urandom_range(0, 1) ? k + 32'd1 : k - 32'd1;
                    else if (pick < 88) k = $urandom;
                    else if (pick < 93) k = $urandom_range(0, 1) ? '0 : '1;
                    else k = $urandom_range(0, 1) ? shadow_key[0] - 32'd1 : shadow_key[n - 1] + 32'd1;
                    lookup(k);
                end
            end
            phase++;
        end
        calm = 1'b0;

        settle();
        repeat (50) @(negedge aclk);
        $display("Run covered %0d lookups (%0d hits) and %0d table/model writes over %0d settings.",
                 n_lookups, hits, n_writes, n_settings);
        $display("Included empty and saturated tables, fanouts 1 to 256, steps 0 to 8191, and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
src/lil_pkg.sv
src/lil_ram.sv
src/lil_model_eval.sv
src/lil_ctrl.sv
src/learned_index_lookup.sv
bench/lookup_checker.sv
bench/tb.sv
